/* rtl/ppp_pkg.sv */
// Shared constants and pipeline word types for the point projection block.
`default_nettype none
package ppp_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] REG_FOCAL_X   = 3'd0;
   localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
   localparam logic [2:0] REG_CENTER_X  = 3'd2;
   localparam logic [2:0] REG_CENTER_Y  = 3'd3;
   localparam logic [2:0] REG_ROT_ROW0  = 3'd4;
   localparam logic [2:0] REG_ROT_ROW1  = 3'd5;
   localparam logic [2:0] REG_ROT_ROW2  = 3'd6;
   localparam logic [2:0] REG_TRANSLATE = 3'd7;

   // Register reset values (identity rotation, no translation)
   localparam logic [15:0] FOCAL_X_RST  = 16'd8192;
   localparam logic [15:0] FOCAL_Y_RST  = 16'd8192;
   localparam logic [15:0] CENTER_X_RST = 16'd5120;
   localparam logic [15:0] CENTER_Y_RST = 16'd3840;
   localparam logic [47:0] ROT_ROW0_RST = 48'h0000_0000_4000;
   localparam logic [47:0] ROT_ROW1_RST = 48'h0000_4000_0000;
   localparam logic [47:0] ROT_ROW2_RST = 48'h4000_0000_0000;
   localparam logic [62:0] TRANS_RST    = 63'd0;

   // Quotient bits produced by the divider chain
   localparam int QUO_BITS = 21;

   localparam logic signed [19:0] PIX_MAX = 20'sd524287;
   localparam logic signed [19:0] PIX_MIN = -20'sd524288;
   localparam logic signed [20:0] DEP_MAX = 21'sd1048575;
   localparam logic signed [20:0] DEP_MIN = -21'sd1048576;

   // One lane of the rounding divider
   typedef struct packed {
      logic [56:0]         rem;   // running remainder of 2|n| + d
      logic [40:0]         den;   // 2d
      logic [QUO_BITS-1:0] quo;
      logic                ovf;   // quotient too large for the pixel range
      logic                neg;   // numerator was negative
   } div_lane_type;

   typedef struct packed {
      div_lane_type        u;
      div_lane_type        v;
      logic signed [20:0]  depth;
      logic                front;
   } div_word_type;

endpackage
`default_nettype wire

/* rtl/ppp_transform.sv */
// Rigid transform into the camera frame: product stage, then sum stage.
`default_nettype none
module ppp_transform
   import ppp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               en_prod,
   input  wire logic               en_sum,
   input  wire logic signed [20:0] world_x,
   input  wire logic signed [20:0] world_y,
   input  wire logic signed [20:0] world_z,
   input  wire logic [47:0]        rot_row0,
   input  wire logic [47:0]        rot_row1,
   input  wire logic [47:0]        rot_row2,
   input  wire logic [62:0]        translation,
   output logic signed [39:0]      cam_x,
   output logic signed [39:0]      cam_y,
   output logic signed [39:0]      cam_z
);

   logic signed [36:0] prod_ff [9];
   logic signed [36:0] prod_in [9];
   logic signed [34:0] trans_ff [3];
   logic signed [34:0] trans_in [3];
   logic signed [20:0] pt [3];
   logic [47:0]        rows [3];
   logic signed [39:0] cam_ff [3];
   logic signed [39:0] cam_in [3];

   assign pt[0]   = world_x;
   assign pt[1]   = world_y;
   assign pt[2]   = world_z;
   assign rows[0] = rot_row0;
   assign rows[1] = rot_row1;
   assign rows[2] = rot_row2;

   // Nine Q1.14 x Q10.10 products, translation moved to Q.24
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[3*r+c] = 37'($signed(rows[r][16*c +: 16]) * pt[c]);
         end
         trans_in[r] = {$signed(translation[21*r +: 21]), 14'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (en_prod) begin
         prod_ff  <= prod_in;
         trans_ff <= trans_in;
      end
   end

   // Row sums
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         cam_in[r] = 40'(prod_ff[3*r]) + 40'(prod_ff[3*r+1]) + 40'(prod_ff[3*r+2])
                   + 40'(trans_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (en_sum) begin
         cam_ff <= cam_in;
      end
   end

   assign cam_x = cam_ff[0];
   assign cam_y = cam_ff[1];
   assign cam_z = cam_ff[2];

endmodule
`default_nettype wire

/* rtl/ppp_div_step.sv */
// One restoring step of the rounding divider: settles one quotient bit.
`default_nettype none
module ppp_div_step
   import ppp_pkg::*;
#(
   parameter int BIT = 0
)
(
   input  wire div_lane_type lane_in,
   output div_lane_type      lane_out
);

   logic [61:0] trial;
   logic [61:0] rem_ext;

   assign trial   = 62'(lane_in.den) << BIT;
   assign rem_ext = 62'(lane_in.rem);

   always_comb begin
      lane_out = lane_in;
      if (rem_ext >= trial) begin
         lane_out.rem      = lane_in.rem - trial[56:0];
         lane_out.quo[BIT] = 1'b1;
      end
   end

endmodule
`default_nettype wire

/* rtl/pinhole_point_projection.sv */
// Top level: pinhole projection of a world point to pixel coordinates.
//
//  channel | dir | word contents
//  req     | in  | world_x, world_y, world_z (21b signed each)
//  rsp     | out | pixel_u, pixel_v (20b), depth (21b); tuser = in_front
//  csr     | in  | write only, index 0..7, 63b data
//
// 26 register stages: 2 transform, 1 focal multiply, 1 divider set-up,
// 21 divider steps (one quotient bit each), 1 output. One point per cycle
// while rsp_tready is high. Each stage advances when it is empty or its
// successor advances, so stalls fill bubbles and drop nothing. Reset is
// synchronous, clears the valid bits and loads the config registers with
// their reset values; the datapath holds no state between points.
`default_nettype none
module pinhole_point_projection
   import ppp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // world_x, world_y, world_z, pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // pixel_u, pixel_v, depth, pad
   output logic [0:0]       rsp_tuser,   // in_front
   input  wire logic        csr_wr,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [62:0] csr_wdata
);

   localparam int NSTG = QUO_BITS + 5;
   localparam int DIV0 = 4;             // first divider step stage

   logic [15:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [47:0] rot0_ff, rot1_ff, rot2_ff;
   logic [62:0] trans_ff;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= FOCAL_X_RST;
         focal_y_ff  <= FOCAL_Y_RST;
         center_x_ff <= CENTER_X_RST;
         center_y_ff <= CENTER_Y_RST;
         rot0_ff     <= ROT_ROW0_RST;
         rot1_ff     <= ROT_ROW1_RST;
         rot2_ff     <= ROT_ROW2_RST;
         trans_ff    <= TRANS_RST;
      end else if (csr_wr) begin
         unique case (csr_addr)
            REG_FOCAL_X:   focal_x_ff  <= csr_wdata[15:0];
            REG_FOCAL_Y:   focal_y_ff  <= csr_wdata[15:0];
            REG_CENTER_X:  center_x_ff <= csr_wdata[15:0];
            REG_CENTER_Y:  center_y_ff <= csr_wdata[15:0];
            REG_ROT_ROW0:  rot0_ff     <= csr_wdata[47:0];
            REG_ROT_ROW1:  rot1_ff     <= csr_wdata[47:0];
            REG_ROT_ROW2:  rot2_ff     <= csr_wdata[47:0];
            REG_TRANSLATE: trans_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Valid bits and per-stage advance
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || rsp_tready;
      for (int i = NSTG-2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign vld_in = {vld_ff[NSTG-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_tready = en[0];

   // Stages 0 and 1: camera-frame point
   logic signed [39:0] cam_x, cam_y, cam_z;

   ppp_transform u_transform (
      .clock       (clock),
      .en_prod     (en[0]),
      .en_sum      (en[1]),
      .world_x     (req_tdata[20:0]),
      .world_y     (req_tdata[41:21]),
      .world_z     (req_tdata[62:42]),
      .rot_row0    (rot0_ff),
      .rot_row1    (rot1_ff),
      .rot_row2    (rot2_ff),
      .translation (trans_ff),
      .cam_x       (cam_x),
      .cam_y       (cam_y),
      .cam_z       (cam_z)
   );

   // Stage 2: focal multiply, depth rounding
   logic signed [56:0] num_u_ff, num_v_ff;
   logic signed [39:0] zc_ff;
   logic signed [20:0] depth2_ff;
   logic signed [20:0] depth2_in;
   logic signed [40:0] zr;
   logic signed [26:0] zq;

   assign zr = 41'(cam_z) + 41'sd8192;
   assign zq = 27'(zr >>> 14);

   always_comb begin
      if (zq > 27'(DEP_MAX)) begin
         depth2_in = DEP_MAX;
      end else if (zq < 27'(DEP_MIN)) begin
         depth2_in = DEP_MIN;
      end else begin
         depth2_in = zq[20:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         num_u_ff  <= 57'($signed({1'b0, focal_x_ff}) * cam_x);
         num_v_ff  <= 57'($signed({1'b0, focal_y_ff}) * cam_y);
         zc_ff     <= cam_z;
         depth2_ff <= depth2_in;
      end
   end

   // Stage 3: divider set-up, N = 2|n| + d, D = 2d
   div_word_type div_ff [QUO_BITS+1];
   div_word_type div_in [QUO_BITS+1];
   logic [40:0]  den;

   function automatic div_lane_type lane_setup(logic signed [56:0] n,
                                               logic [38:0] d,
                                               logic [40:0] dd);
      div_lane_type l;
      logic [56:0]  mag;
      mag     = n[56] ? 57'(-n) : 57'(n);
      l.rem   = {mag[55:0], 1'b0} + 57'(d);
      l.den   = dd;
      l.quo   = '0;
      l.ovf   = 41'(l.rem[56:QUO_BITS]) >= dd;
      l.neg   = n[56];
      return l;
   endfunction

   assign den = {1'b0, zc_ff[38:0], 1'b0};

   assign div_in[0].u     = lane_setup(num_u_ff, zc_ff[38:0], den);
   assign div_in[0].v     = lane_setup(num_v_ff, zc_ff[38:0], den);
   assign div_in[0].depth = depth2_ff;
   assign div_in[0].front = zc_ff > 40'sd0;

   // Divider steps, most significant quotient bit first
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      ppp_div_step #(.BIT(QUO_BITS-1-k)) u_step_u (
         .lane_in  (div_ff[k].u),
         .lane_out (div_in[k+1].u)
      );
      ppp_div_step #(.BIT(QUO_BITS-1-k)) u_step_v (
         .lane_in  (div_ff[k].v),
         .lane_out (div_in[k+1].v)
      );
      assign div_in[k+1].depth = div_ff[k].depth;
      assign div_in[k+1].front = div_ff[k].front;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QUO_BITS; k++) begin
         if (en[DIV0-1+k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // Final stage: sign, principal point, saturation
   function automatic logic [19:0] pix_finish(div_lane_type l, logic [15:0] c,
                                              logic front);
      logic signed [22:0] q;
      logic signed [22:0] s;
      logic [19:0]        r;
      q = $signed({2'b00, l.quo});
      s = (l.neg ? -q : q) + $signed({7'd0, c});
      if (!front) begin
         r = '0;
      end else if (l.ovf) begin
         r = l.neg ? PIX_MIN : PIX_MAX;
      end else if (s > 23'(PIX_MAX)) begin
         r = PIX_MAX;
      end else if (s < 23'(PIX_MIN)) begin
         r = PIX_MIN;
      end else begin
         r = s[19:0];
      end
      return r;
   endfunction

   logic [19:0] pix_u_ff, pix_v_ff;
   logic [20:0] depth_ff;
   logic        front_ff;

   always_ff @(posedge clock) begin
      if (en[NSTG-1]) begin
         pix_u_ff <= pix_finish(div_ff[QUO_BITS].u, center_x_ff, div_ff[QUO_BITS].front);
         pix_v_ff <= pix_finish(div_ff[QUO_BITS].v, center_y_ff, div_ff[QUO_BITS].front);
         depth_ff <= div_ff[QUO_BITS].depth;
         front_ff <= div_ff[QUO_BITS].front;
      end
   end

   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = {3'd0, depth_ff, pix_v_ff, pix_u_ff};
   assign rsp_tuser  = front_ff;

endmodule
`default_nettype wire

/* verif/tb_pinhole_point_projection.sv */
// Testbench for pinhole_point_projection: directed table plus random points, scoreboard check.
`timescale 1ns / 1ps
`default_nettype none
module tb_pinhole_point_projection
   import ppp_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_wr = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [62:0] csr_wdata = '0;

   pinhole_point_projection u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr(csr_wr), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic signed [19:0] u;
      logic signed [19:0] v;
      logic signed [20:0] depth;
      logic               front;
   } pixel_type;

   typedef struct {
      logic [62:0] pt;
      logic        chk;   // 1: compare against typed pixel
      pixel_type   pix;
   } row_type;

   // shadow copy of the camera registers
   logic [15:0] fx, fy, cx, cy;
   logic [47:0] rot [3];
   logic [62:0] trans;

   pixel_type pixel_queue [$];
   row_type   rows [$];
   int        errors = 0;
   bit        hold_long = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb_pinhole_point_projection: errors");
      $finish;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
   endtask

   // append one expected word to the scoreboard
   task automatic expect_word(input pixel_type p);
      pixel_queue.insert(pixel_queue.size(), p);
   endtask

   task automatic add_row(input logic [62:0] pt, input bit chk, input pixel_type pix);
      row_type r;
      r.pt = pt;
      r.chk = chk;
      r.pix = pix;
      rows.insert(rows.size(), r);
   endtask

   function automatic longint div_nearest(input longint n, input longint d);
      longint mag, q;
      mag = (n < 0) ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   // camera-frame projection of one world point
   function automatic pixel_type project_point(input logic [62:0] pt);
      longint w [3];
      longint c [3];
      longint dep, u, v;
      pixel_type p;
      for (int k = 0; k < 3; k++) w[k] = longint'($signed(pt[21*k +: 21]));
      for (int r = 0; r < 3; r++) begin
         c[r] = longint'($signed(trans[21*r +: 21])) * 16384;
         for (int j = 0; j < 3; j++)
            c[r] += longint'($signed(rot[r][16*j +: 16])) * w[j];
      end
      dep = c[2] + 8192;
      dep = (dep >= 0) ? (dep >>> 14) : -((-dep + 16383) >>> 14);
      p.depth = 21'(clip(dep, -1048576, 1048575));
      p.front = c[2] > 0;
      u = 0; v = 0;
      if (p.front) begin
         u = clip(div_nearest(longint'(fx) * c[0], c[2]) + longint'(cx), -524288, 524287);
         v = clip(div_nearest(longint'(fy) * c[1], c[2]) + longint'(cy), -524288, 524287);
      end
      p.u = 20'(u);
      p.v = 20'(v);
      return p;
   endfunction

   function automatic logic [62:0] pack_point(input int x, input int y, input int z);
      return {21'(z), 21'(y), 21'(x)};
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [62:0] val);
      @(negedge clock);
      csr_wr <= 1'b1; csr_addr <= idx; csr_wdata <= val;
      case (idx)
         REG_FOCAL_X:   fx = val[15:0];
         REG_FOCAL_Y:   fy = val[15:0];
         REG_CENTER_X:  cx = val[15:0];
         REG_CENTER_Y:  cy = val[15:0];
         REG_ROT_ROW0:  rot[0] = val[47:0];
         REG_ROT_ROW1:  rot[1] = val[47:0];
         REG_ROT_ROW2:  rot[2] = val[47:0];
         REG_TRANSLATE: trans = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wr <= 1'b0;
   endtask

   // wait out the pipeline before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic send_point(input logic [62:0] pt, input bit chk, input pixel_type want,
                             input int gap_max);
      pixel_type p;
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, gap_max) : $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, pt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = project_point(pt);
      if (chk) begin
         if (p !== want) report("table row vs predictor", 64'(p), 64'(want));
         expect_word(want);
      end else
         expect_word(p);
      @(negedge clock);
   endtask

   function automatic logic [47:0] rand_row();
      logic [47:0] r;
      for (int j = 0; j < 3; j++) r[16*j +: 16] = 16'($urandom_range(0, 32767) - 16384);
      if ($urandom_range(0, 7) == 0) r = 48'({$urandom, $urandom});
      return r;
   endfunction

   function automatic logic [62:0] rand_point();
      logic [62:0] pt;
      case ($urandom_range(0, 3))
         0: pt = 63'({$urandom, $urandom});
         1: pt = pack_point($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                            $urandom_range(0, 8000) - 1000);
         default: pt = pack_point($urandom_range(0, 400000) - 200000,
                                  $urandom_range(0, 400000) - 200000,
                                  $urandom_range(0, 600000) - 100000);
      endcase
      return pt;
   endfunction

   // result checker
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_queue.size() == 0)
            report("word with nothing expected", rsp_tdata, 0);
         else begin
            want = pixel_queue.pop_front();
            if ($signed(rsp_tdata[19:0]) !== want.u) report("pixel_u", rsp_tdata[19:0], want.u);
            if ($signed(rsp_tdata[39:20]) !== want.v) report("pixel_v", rsp_tdata[39:20], want.v);
            if ($signed(rsp_tdata[60:40]) !== want.depth)
               report("depth", rsp_tdata[60:40], want.depth);
            if (rsp_tuser[0] !== want.front) report("in_front", rsp_tuser, want.front);
         end
      end
   end

   // receiver stalls, plus one long hold-off
   initial begin
      int n;
      @(negedge clock);
      while (!reset) @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_tready <= 1'b0;
            repeat (200) @(negedge clock);
            hold_long = 0;
         end
         rsp_tready <= 1'b1;
         n = $urandom_range(0, 7) == 0 ? $urandom_range(1, 30) : $urandom_range(1, 6);
         repeat (n) @(negedge clock);
         if ($urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3);
            repeat (n) @(negedge clock);
         end
      end
   end

   // stimulus
   initial begin
      pixel_type none;
      int waited;
      none = '0;
      fx = FOCAL_X_RST; fy = FOCAL_Y_RST; cx = CENTER_X_RST; cy = CENTER_Y_RST;
      rot[0] = ROT_ROW0_RST; rot[1] = ROT_ROW1_RST; rot[2] = ROT_ROW2_RST;
      trans = TRANS_RST;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset camera: identity, f=8192, c=(5120,3840)
      add_row(pack_point(0, 0, 1024), 1, '{5120, 3840, 1024, 1});
      add_row(pack_point(0, 0, 0), 1, '{0, 0, 0, 0});
      add_row(pack_point(5, 5, -1024), 1, '{0, 0, -1024, 0});
      add_row(pack_point(1024, -1024, 1024), 1, '{5120 + 8192, 3840 - 8192, 1024, 1});
      add_row(pack_point(0, 0, 1048575), 1, '{5120, 3840, 1048575, 1});
      add_row(pack_point(0, 0, -1048576), 1, '{0, 0, -1048576, 0});
      add_row(pack_point(1048575, -1048576, 1), 1, '{524287, -524288, 1, 1});
      add_row(pack_point(-1048576, 1048575, 1), 1, '{-524288, 524287, 1, 1});
      add_row(pack_point(-1048576, -1048576, -1048576), 1, '{0, 0, -1048576, 0});
      add_row(pack_point(1048575, 1048575, 1048575), 0, none);
      add_row(pack_point(1, 1, 1), 0, none);
      add_row(pack_point(-1, 3, 7), 0, none);
      add_row(pack_point(512, 512, 512), 0, none);
      add_row(pack_point(-700, 300, 2048), 0, none);
      foreach (rows[i]) send_point(rows[i].pt, rows[i].chk, rows[i].pix, 4);
      drain();

      // extreme register settings
      write_reg(REG_FOCAL_X, 63'hFFFF);
      write_reg(REG_FOCAL_Y, 63'h0);
      write_reg(REG_CENTER_X, 63'h0);
      write_reg(REG_CENTER_Y, 63'hFFFF);
      write_reg(REG_ROT_ROW0, {15'h0, 48'h8000_7FFF_8000});
      write_reg(REG_ROT_ROW1, {15'h0, 48'h7FFF_8000_7FFF});
      write_reg(REG_ROT_ROW2, {15'h0, 48'h7FFF_7FFF_7FFF});
      write_reg(REG_TRANSLATE, 63'h7FFF_FFFF_FFFF_FFFF);
      for (int i = 0; i < 10; i++) send_point(rand_point(), 0, none, 4);
      drain();
      write_reg(REG_TRANSLATE, {21'h100000, 21'h100000, 21'h100000});
      write_reg(REG_ROT_ROW2, {15'h0, 48'h8000_8000_8000});
      for (int i = 0; i < 10; i++) send_point(rand_point(), 0, none, 4);
      drain();

      // random phases with fresh camera settings
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_FOCAL_X, 63'($urandom_range(0, 65535)));
         write_reg(REG_FOCAL_Y, 63'($urandom_range(0, 65535)));
         write_reg(REG_CENTER_X, 63'($urandom_range(0, 65535)));
         write_reg(REG_CENTER_Y, 63'($urandom_range(0, 65535)));
         write_reg(REG_ROT_ROW0, {15'h0, rand_row()});
         write_reg(REG_ROT_ROW1, {15'h0, rand_row()});
         write_reg(REG_ROT_ROW2, {15'h0, rand_row()});
         write_reg(REG_TRANSLATE, (ph % 3 == 0) ? 63'({$urandom, $urandom})
                   : {21'($urandom_range(0, 20000) - 10000), 21'($urandom_range(0, 20000) - 10000),
                      21'($urandom_range(0, 40000) - 5000)});
         if (ph == 3) hold_long = 1;
         for (int i = 0; i < 110; i++) send_point(rand_point(), 0, none, 40);
         drain();
      end

      waited = 0;
      while (pixel_queue.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (40) @(negedge clock);
      if (errors == 0 && pixel_queue.size() == 0)
         $display("tb_pinhole_point_projection: clean");
      else
         $display("tb_pinhole_point_projection: errors");
      $finish;
   end

endmodule
`default_nettype wire
